// ===== rtl/core/min_tracking_stack_assert.svh =====
// ----------------------------------------------------------------------------
// Min-tracking stack assertion macros
// Shared concurrent assertion forms for the stack RTL.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// Checked only while out of reset.
`define MTS_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack package
// Depth, codes and transfer types shared by the stack modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int OCC_W       = 11;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_TOP  = 2'd2,
        OP_MIN  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                      operation;
        logic signed [VAL_W-1:0]  push_value;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_result;

    // One stack slot: the value and the least value at or below it.
    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic signed [VAL_W-1:0]  run_min;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

// ===== rtl/core/min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack
// LIFO of signed 32-bit values that also reports the least value held.
// ----------------------------------------------------------------------------
// One command is taken per clock: busy never rises, so start may be held
// high every cycle. Each command's result appears on o_result with o_done
// high in the cycle right after the transfer, for exactly one cycle; there is
// no backpressure, so the result must be captured then. The stack is a row of
// STACK_DEPTH shifting cells with the top always in the first cell, and each
// cell keeps the minimum of itself and everything below it, so every command
// looks at the first cell only. A push on a full stack, or a pop or read on
// an empty one, changes nothing and is flagged in the status field. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "min_tracking_stack_assert.svh"

module min_tracking_stack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mts_pkg::t_cmd     i_cmd,
    output logic              o_done,
    output mts_pkg::t_result  o_result
);

    logic [mts_pkg::CNT_W-1:0] r_count;
    logic [mts_pkg::CNT_W-1:0] n_count;
    logic                      r_done;
    mts_pkg::t_result          r_result;
    mts_pkg::t_result          n_result;

    logic                      w_accept;
    logic                      w_empty;
    logic                      w_full;
    logic                      w_over;
    mts_pkg::t_shift_ctl       w_ctl;
    mts_pkg::t_entry           w_new;
    mts_pkg::t_entry           w_top;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH));
    assign w_over   = (r_count > mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH));

    // New top slot: keep the older minimum only when strictly smaller.
    always_comb begin
        w_new.value   = i_cmd.push_value;
        w_new.run_min = i_cmd.push_value;
        if (!w_empty && (w_top.run_min < i_cmd.push_value)) begin
            w_new.run_min = w_top.run_min;
        end
    end

    always_comb begin
        w_ctl               = '0;
        n_count             = r_count;
        n_result.read_value = '0;
        n_result.status     = mts_pkg::ST_OK;
        if (w_accept) begin
            case (i_cmd.operation)
                mts_pkg::OP_PUSH: begin
                    if (w_full) begin
                        n_result.status = mts_pkg::ST_FULL;
                    end else begin
                        w_ctl.push = 1'b1;
                        n_count    = r_count + 1'b1;
                    end
                end
                mts_pkg::OP_POP: begin
                    if (w_empty) begin
                        n_result.status = mts_pkg::ST_EMPTY;
                    end else begin
                        w_ctl.pop = 1'b1;
                        n_count   = r_count - 1'b1;
                    end
                end
                mts_pkg::OP_TOP: begin
                    if (w_empty) begin
                        n_result.status = mts_pkg::ST_EMPTY;
                    end else begin
                        n_result.read_value = w_top.value;
                    end
                end
                mts_pkg::OP_MIN: begin
                    if (w_empty) begin
                        n_result.status = mts_pkg::ST_EMPTY;
                    end else begin
                        n_result.read_value = w_top.run_min;
                    end
                end
                default: begin
                    n_result.status = mts_pkg::ST_OK;
                end
            endcase
        end
        n_result.occupancy = mts_pkg::OCC_W'(n_count);
    end

    mts_chain u_chain (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_new (w_new),
        .o_top (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `MTS_ASSERT_RUN(a_count_bound, !w_over, "count beyond depth")
    `MTS_ASSERT_RUN(a_done_follows, w_accept |=> o_done, "missing result strobe")
    `MTS_ASSERT_RUN(a_no_spurious, !w_accept |=> !o_done, "result strobe without transfer")
    `MTS_ASSERT_RUN(a_push_grows, w_ctl.push |=> r_count == $past(r_count) + 1'b1, "push lost")
    `MTS_ASSERT_RUN(a_top_min, !w_empty |-> (w_top.run_min <= w_top.value), "minimum above value")

endmodule

// ===== rtl/core/mts_cell.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack cell
// One slot of the shifting stack; loads from above on push, from below on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_cell (
    input  logic                  i_clk,
    input  mts_pkg::t_shift_ctl   i_ctl,
    input  mts_pkg::t_entry       i_above,
    input  mts_pkg::t_entry       i_below,
    output mts_pkg::t_entry       o_entry
);

    mts_pkg::t_entry r_entry;
    mts_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            n_entry = i_above;
        end else if (i_ctl.pop) begin
            n_entry = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/mts_chain.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack cell chain
// Row of stack cells; cell 0 always holds the top of the stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_chain (
    input  logic                  i_clk,
    input  mts_pkg::t_shift_ctl   i_ctl,
    input  mts_pkg::t_entry       i_new,
    output mts_pkg::t_entry       o_top
);

    mts_pkg::t_entry w_q [mts_pkg::STACK_DEPTH];

    for (genvar gi = 0; gi < mts_pkg::STACK_DEPTH; gi++) begin : g_cell
        mts_pkg::t_entry w_above;
        mts_pkg::t_entry w_below;

        if (gi == 0) begin : g_head
            assign w_above = i_new;
        end else begin : g_mid
            assign w_above = w_q[gi-1];
        end

        // The bottom cell loads zero on pop; its slot is dead after it.
        if (gi == mts_pkg::STACK_DEPTH - 1) begin : g_tail
            assign w_below = '0;
        end else begin : g_body
            assign w_below = w_q[gi+1];
        end

        mts_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_above (w_above),
            .i_below (w_below),
            .o_entry (w_q[gi])
        );
    end

    assign o_top = w_q[0];

endmodule

// ===== bench/tb_min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// Min-tracking stack testbench
// Drives push, pop, top and minimum commands through the start/busy
// handshake, predicts every result from a local copy of the stack and its
// running minima, and compares each strobed result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_min_tracking_stack;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 430;
    localparam int IDLE_PCT     = 18;

    // Expected results and the stack state they are computed from.
    class stack_scoreboard;
        mts_pkg::t_result                 pending_results[$];
        logic signed [mts_pkg::VAL_W-1:0] held_values[mts_pkg::STACK_DEPTH];
        logic signed [mts_pkg::VAL_W-1:0] held_minima[mts_pkg::STACK_DEPTH];
        int unsigned                      depth_used;
        int                               errors;
        int                               checked;
        int                               full_hits;
        int                               empty_hits;
        int unsigned                      peak;

        function void note_command(mts_pkg::t_cmd cmd);
            mts_pkg::t_result                 exp_res;
            logic signed [mts_pkg::VAL_W-1:0] new_min;
            exp_res.read_value = '0;
            exp_res.status     = mts_pkg::ST_OK;
            if (cmd.operation == mts_pkg::OP_PUSH) begin
                if (depth_used >= mts_pkg::STACK_DEPTH) begin
                    exp_res.status = mts_pkg::ST_FULL;
                    full_hits++;
                end else begin
                    new_min = cmd.push_value;
                    if (depth_used > 0 && held_minima[depth_used-1] < cmd.push_value)
                        new_min = held_minima[depth_used-1];
                    held_values[depth_used] = cmd.push_value;
                    held_minima[depth_used] = new_min;
                    depth_used++;
                    if (depth_used > peak)
                        peak = depth_used;
                end
            end else if (depth_used == 0) begin
                exp_res.status = mts_pkg::ST_EMPTY;
                empty_hits++;
            end else if (cmd.operation == mts_pkg::OP_POP) begin
                depth_used--;
            end else if (cmd.operation == mts_pkg::OP_TOP) begin
                exp_res.read_value = held_values[depth_used-1];
            end else begin
                exp_res.read_value = held_minima[depth_used-1];
            end
            exp_res.occupancy = mts_pkg::OCC_W'(depth_used);
            pending_results.insert(pending_results.size(), exp_res);
        endfunction

        function void check_result(mts_pkg::t_result got);
            mts_pkg::t_result exp_res;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: value %0d status %0d occupancy %0d",
                       got.read_value, got.status, got.occupancy);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            checked++;
            if (got.read_value !== exp_res.read_value) begin
                $error("read_value: expected %0d, got %0d", exp_res.read_value, got.read_value);
                errors++;
            end
            if (got.status !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, got.status);
                errors++;
            end
            if (got.occupancy !== exp_res.occupancy) begin
                $error("occupancy: expected %0d, got %0d", exp_res.occupancy, got.occupancy);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    mts_pkg::t_cmd    i_cmd;
    logic             o_done;
    mts_pkg::t_result o_result;

    stack_scoreboard sb = new;

    bit          idle_on = 1'b1;
    int unsigned level;

    min_tracking_stack dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Check the strobed result first; a command taken at this edge answers later.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_result(o_result);
            if (start && !busy)
                sb.note_command(i_cmd);
        end
    end

    function automatic logic signed [mts_pkg::VAL_W-1:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(9, 0);
        if (pick <= 4)
            return $urandom;
        else if (pick <= 7)
            return $signed($urandom_range(20, 0)) - 10;   // clustered, for equal minima
        else if (pick == 8)
            return 32'sh7fff_ffff;
        else
            return 32'sh8000_0000;
    endfunction

    task automatic send_cmd(input mts_pkg::t_op op,
                            input logic signed [mts_pkg::VAL_W-1:0] value);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99, 0) < IDLE_PCT) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start            <= 1'b1;
        i_cmd.operation  <= op;
        i_cmd.push_value <= value;
        // Hold the command until the transfer.
        do @(posedge i_clk); while (busy);
        if (op == mts_pkg::OP_PUSH && level < mts_pkg::STACK_DEPTH)
            level++;
        else if (op == mts_pkg::OP_POP && level > 0)
            level--;
    endtask

    task automatic send_random_cmd();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (level < 4)
            roll = roll / 2;   // lean toward push near the bottom
        if (roll < 45)
            send_cmd(mts_pkg::OP_PUSH, rand_value());
        else if (roll < 75)
            send_cmd(mts_pkg::OP_POP, $urandom);
        else if (roll < 88)
            send_cmd(mts_pkg::OP_TOP, $urandom);
        else
            send_cmd(mts_pkg::OP_MIN, $urandom);
    endtask

    initial begin
        #(CLK_PERIOD * 200000);
        $display("[min_tracking_stack] ERROR");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        level   = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty stack reads and pop, extremes, equal minima.
        send_cmd(mts_pkg::OP_POP, 32'sh7fff_ffff);
        send_cmd(mts_pkg::OP_TOP, '0);
        send_cmd(mts_pkg::OP_MIN, '1);
        send_cmd(mts_pkg::OP_PUSH, 32'sh7fff_ffff);
        send_cmd(mts_pkg::OP_MIN, '0);
        send_cmd(mts_pkg::OP_PUSH, 32'sh8000_0000);
        send_cmd(mts_pkg::OP_TOP, '0);
        send_cmd(mts_pkg::OP_MIN, '0);
        send_cmd(mts_pkg::OP_PUSH, 32'sh0000_0000);
        send_cmd(mts_pkg::OP_PUSH, 32'sh8000_0000);
        send_cmd(mts_pkg::OP_MIN, '0);
        send_cmd(mts_pkg::OP_POP, '0);
        send_cmd(mts_pkg::OP_MIN, '0);
        send_cmd(mts_pkg::OP_POP, '0);
        send_cmd(mts_pkg::OP_TOP, '0);
        send_cmd(mts_pkg::OP_PUSH, -32'sd1);
        send_cmd(mts_pkg::OP_TOP, '0);
        send_cmd(mts_pkg::OP_MIN, '0);
        send_cmd(mts_pkg::OP_POP, '0);
        send_cmd(mts_pkg::OP_POP, '0);
        send_cmd(mts_pkg::OP_POP, '0);
        send_cmd(mts_pkg::OP_POP, '0);
        send_cmd(mts_pkg::OP_MIN, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on = !(i >= 150 && i < 300);
            send_random_cmd();
        end
        idle_on = 1'b1;

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Checked %0d results, deepest level %0d of %0d", sb.checked, sb.peak,
                 mts_pkg::STACK_DEPTH);
        $display("Pushes on a full stack: %0d, commands on an empty stack: %0d",
                 sb.full_hits, sb.empty_hits);
        if (sb.errors == 0)
            $display("[min_tracking_stack] OK");
        else
            $display("[min_tracking_stack] ERROR");
        $finish;
    end

endmodule
